@@ src/wvm_pkg.sv @@
// Shared types and constants of the wavetable voice mixer.
package wvm_pkg;

  // Item codes carried in the action field
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SETUP = 2'd1,
    ACT_MIX   = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX_SEL,
    ST_MIX_MUL,
    ST_MIX_ACC,
    ST_SET_MUL,
    ST_SET_WR,
    ST_READ,
    ST_EMIT
  } state_e;

  // Envelope is reduced to its upper bits before scaling the volume
  localparam int EnvShift = 9;
  localparam int EnvBits  = 16 - EnvShift;
  // Products are in 1/256 units
  localparam int FracBits = 8;

  // One voice record
  typedef struct packed {
    logic [15:0] pos_int;
    logic [7:0]  pos_frac;
    logic [15:0] speed;
    logic [15:0] start_addr;
    logic [15:0] end_addr;
    logic [15:0] loop_span;
    logic [7:0]  gain;
  } voice_t;

endpackage

@@ src/wvm_if.sv @@
// Channel interfaces: item input, result output and configuration write.
interface wvm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [15:0]        mem_address;
  logic signed [7:0]  sample_byte;
  logic [2:0]         voice;
  logic [15:0]        start_address;
  logic [15:0]        sample_length;
  logic [15:0]        loop_length;
  logic [23:0]        start_position;
  logic [15:0]        step_speed;
  logic [7:0]         voice_volume;
  logic [15:0]        envelope_level;

  modport source (
    output valid, action, mem_address, sample_byte, voice, start_address, sample_length,
           loop_length, start_position, step_speed, voice_volume, envelope_level,
    input  ready
  );
  modport sink (
    input  valid, action, mem_address, sample_byte, voice, start_address, sample_length,
           loop_length, start_position, step_speed, voice_volume, envelope_level,
    output ready
  );
endinterface

interface wvm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mixed_sample;
  logic [23:0]        voice_position;
  logic [15:0]        voice_speed;

  modport source (
    output valid, mixed_sample, voice_position, voice_speed,
    input  ready
  );
  modport sink (
    input  valid, mixed_sample, voice_position, voice_speed,
    output ready
  );
endinterface

interface wvm_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

@@ src/wavetable_voice_mixer_core.sv @@
// Wavetable voice mixer: top level with sequencer, sample RAM and shared multiplier.
//
// Takes one word at a time and drops ready until it is done. A load word writes one
// signed byte into the sample RAM in the same cycle that it is accepted. A set-up
// word forms the gain in ST_SET_MUL on the shared multiplier (volume times the top 7
// envelope bits, over 256), then writes the voice record in ST_SET_WR; a set-up of a
// voice index at or above VOICES is dropped. A read word passes ST_READ and then
// waits in ST_EMIT for the output register. A mix word walks the voices
// 0 to min(active_voices, VOICES)-1 through the one sample RAM port and the one
// multiplier: a voice with zero speed is skipped in ST_MIX_SEL, a moving voice goes
// through RAM read, multiply plus position step and accumulate, and the walk ends in
// ST_EMIT. The result sits in an output register, so the next word is taken while
// the result waits. The sample RAM has no reset; reading a byte never written
// returns whatever the RAM holds.
module wavetable_voice_mixer_core import wvm_pkg::*; #(
  parameter int VOICES           = 8,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic clk_i,
  input  logic rst_ni,
  wvm_cfg_if.sink   cfg_i,
  wvm_in_if.sink    item_i,
  wvm_out_if.source res_o
);

  localparam int AW  = $clog2(SAMPLE_MEM_DEPTH);
  localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW  = $clog2(VOICES + 1);

  state_e state_q, state_d;

  // configuration
  logic [3:0] active_q;

  // latched word fields
  logic [2:0]  vsel_q;
  logic [15:0] start_q, len_q, loop_q, speed_q, env_q;
  logic [23:0] spos_q;
  logic [7:0]  vol_q;

  // mix walk
  logic [CW-1:0] cnt_q, cnt_d, voice_lim;
  logic [15:0]   acc_q, acc_d;

  // pending result and output register
  logic [15:0] res_mix_q, res_mix_d, res_spd_q, res_spd_d;
  logic [23:0] res_pos_q, res_pos_d;
  logic        out_valid_q, out_load;
  logic [15:0] out_mix_q, out_spd_q;
  logic [23:0] out_pos_q;

  logic in_accept, vsel_ok;

  // shared units
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic              mul_en;
  logic signed [8:0]  mul_a, mul_b;
  logic signed [17:0] mul_prod;

  logic [VIW-1:0] vf_idx;
  logic           vf_we;
  voice_t         vf_wdata, vf_rdata;

  // position step of the voice under the walk
  voice_t      adv;
  logic [8:0]  frac_sum;
  logic [15:0] pos_step, rel_pos;
  logic        past_end;

  wvm_ram #(
    .WIDTH (8),
    .DEPTH (SAMPLE_MEM_DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  wvm_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  wvm_voice_file #(
    .VOICES (VOICES)
  ) u_voice_file (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .idx_i   (vf_idx),
    .we_i    (vf_we),
    .wdata_i (vf_wdata),
    .rdata_o (vf_rdata)
  );

  assign cfg_i.ready = 1'b1;
  assign in_accept   = item_i.valid && item_i.ready;
  assign vsel_ok     = int'(vsel_q) < VOICES;
  // more voices asked for than built: mix all that exist
  assign voice_lim   = (int'(active_q) > VOICES) ? CW'(VOICES) : CW'(active_q);

  // 8.8 step, integer part wraps at 16 bits; at or past the end step back by the loop
  always_comb begin
    frac_sum = {1'b0, vf_rdata.pos_frac} + {1'b0, vf_rdata.speed[7:0]};
    pos_step = vf_rdata.pos_int + {8'd0, vf_rdata.speed[15:8]} + {15'd0, frac_sum[8]};
    past_end = pos_step >= vf_rdata.end_addr;
    adv          = vf_rdata;
    adv.pos_frac = frac_sum[7:0];
    adv.pos_int  = past_end ? (pos_step - vf_rdata.loop_span) : pos_step;
    if (past_end && (vf_rdata.loop_span == 16'd0)) begin
      adv.speed = 16'd0;   // one-shot voice stops
    end
  end

  assign rel_pos = vf_rdata.pos_int - vf_rdata.start_addr;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (action_e'(item_i.action))
            ACT_LOAD:  state_d = ST_IDLE;
            ACT_SETUP: state_d = ST_SET_MUL;
            ACT_MIX:   state_d = ST_MIX_SEL;
            ACT_READ:  state_d = ST_READ;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_MIX_SEL: begin
        if (cnt_q == voice_lim) begin
          state_d = ST_EMIT;
        end else if (vf_rdata.speed != 16'd0) begin
          state_d = ST_MIX_MUL;
        end
      end
      ST_MIX_MUL: state_d = ST_MIX_ACC;
      ST_MIX_ACC: state_d = ST_MIX_SEL;
      ST_SET_MUL: state_d = ST_SET_WR;
      ST_SET_WR:  state_d = ST_IDLE;
      ST_READ:    state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    item_i.ready = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = item_i.mem_address[AW-1:0];
    ram_wdata = item_i.sample_byte;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    vf_idx    = cnt_q[VIW-1:0];
    vf_we     = 1'b0;
    vf_wdata  = vf_rdata;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    res_mix_d = res_mix_q;
    res_pos_d = res_pos_q;
    res_spd_d = res_spd_q;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        item_i.ready = 1'b1;
        if (in_accept) begin
          ram_we = action_e'(item_i.action) == ACT_LOAD;
          cnt_d  = '0;
          acc_d  = '0;
        end
      end
      ST_MIX_SEL: begin
        if (cnt_q == voice_lim) begin
          res_mix_d = acc_q;
          res_pos_d = '0;
          res_spd_d = '0;
        end else if (vf_rdata.speed != 16'd0) begin
          ram_addr = vf_rdata.pos_int[AW-1:0];
        end else begin
          cnt_d = cnt_q + 1'b1;   // silent voice, skip
        end
      end
      ST_MIX_MUL: begin
        mul_en   = 1'b1;
        mul_a    = {ram_rdata[7], ram_rdata};
        mul_b    = {1'b0, vf_rdata.gain};
        vf_we    = 1'b1;
        vf_wdata = adv;
      end
      ST_MIX_ACC: begin
        // floor(sample * gain / 256), sign-extended
        acc_d = acc_q + {{7{mul_prod[16]}}, mul_prod[16:FracBits]};
        cnt_d = cnt_q + 1'b1;
      end
      ST_SET_MUL: begin
        vf_idx = VIW'(vsel_q);
        mul_en = 1'b1;
        mul_a  = {1'b0, vol_q};
        mul_b  = {2'b00, env_q[15:EnvShift]};
      end
      ST_SET_WR: begin
        vf_idx              = VIW'(vsel_q);
        vf_we               = vsel_ok;
        vf_wdata.start_addr = start_q;
        vf_wdata.end_addr   = start_q + len_q;
        vf_wdata.loop_span  = loop_q;
        vf_wdata.pos_int    = start_q + spos_q[23:FracBits];
        vf_wdata.pos_frac   = spos_q[FracBits-1:0];
        vf_wdata.speed      = speed_q;
        vf_wdata.gain       = mul_prod[15:FracBits];
      end
      ST_READ: begin
        vf_idx    = VIW'(vsel_q);
        res_mix_d = '0;
        res_pos_d = vsel_ok ? {rel_pos, vf_rdata.pos_frac} : '0;
        res_spd_d = vsel_ok ? vf_rdata.speed : '0;
      end
      ST_EMIT: begin
        out_load = !out_valid_q || res_o.ready;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 4'd8;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_i.valid && cfg_i.ready) begin
        active_q <= cfg_i.data;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    res_mix_q <= res_mix_d;
    res_pos_q <= res_pos_d;
    res_spd_q <= res_spd_d;
    if (in_accept) begin
      vsel_q  <= item_i.voice;
      start_q <= item_i.start_address;
      len_q   <= item_i.sample_length;
      loop_q  <= item_i.loop_length;
      spos_q  <= item_i.start_position;
      speed_q <= item_i.step_speed;
      vol_q   <= item_i.voice_volume;
      env_q   <= item_i.envelope_level;
    end
    if (out_load) begin
      out_mix_q <= res_mix_q;
      out_pos_q <= res_pos_q;
      out_spd_q <= res_spd_q;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.mixed_sample   = out_mix_q;
  assign res_o.voice_position = out_pos_q;
  assign res_o.voice_speed    = out_spd_q;

endmodule

@@ src/wvm_ram.sv @@
// Generic single-port RAM with registered read data.
module wvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ src/wvm_mul.sv @@
// Shared signed 9x9 multiplier with registered product.
module wvm_mul (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [8:0]  a_i,
  input  logic signed [8:0]  b_i,
  output logic signed [17:0] prod_o
);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= a_i * b_i;
    end
  end

endmodule

@@ src/wvm_voice_file.sv @@
// Per-voice state registers, one read port and one write port at a shared index.
module wvm_voice_file import wvm_pkg::*; #(
  parameter int VOICES = 8,
  localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [VIW-1:0] idx_i,
  input  logic           we_i,
  input  voice_t         wdata_i,
  output voice_t         rdata_o
);

  voice_t voice_q [VOICES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICES; i++) begin
        voice_q[i] <= '0;
      end
    end else if (we_i && (int'(idx_i) < VOICES)) begin
      voice_q[idx_i] <= wdata_i;
    end
  end

  // out-of-range index reads as an idle voice
  assign rdata_o = (int'(idx_i) < VOICES) ? voice_q[idx_i] : '0;

endmodule

@@ verif/wvm_checker.sv @@
// Watches the mixer's channels, predicts each result word and compares it with the DUT.
module wvm_checker import wvm_pkg::*; #(
  parameter int VOICES    = 8,
  parameter int MEM_DEPTH = 65536
) (
  input  logic clk_i,
  input  logic rst_ni,
  wvm_cfg_if   cfg_i,
  wvm_in_if    item_i,
  wvm_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] mixed;
    logic [23:0] position;
    logic [15:0] speed;
  } voice_result_t;

  logic [7:0]    sample_mem [MEM_DEPTH];
  voice_t        voices [VOICES];
  logic [3:0]    active_voices;
  voice_result_t result_q [$];
  int            mismatches = 0;

  assign fail_count_o = mismatches;

  // floor(sample * gain / 256) as a 16-bit pattern
  function automatic logic [15:0] voice_term(input voice_t vr);
    logic signed [7:0] smp;
    int                prod;
    smp  = sample_mem[int'(vr.pos_int) % MEM_DEPTH];
    prod = int'(smp) * int'(vr.gain);
    return 16'(prod >>> FracBits);
  endfunction

  // 8.8 step, then loop back or stop at the end
  function automatic voice_t step_voice(input voice_t vr);
    logic [8:0]  frac_sum;
    logic [15:0] next_pos;
    frac_sum = {1'b0, vr.pos_frac} + {1'b0, vr.speed[7:0]};
    next_pos = vr.pos_int + {8'd0, vr.speed[15:8]} + {15'd0, frac_sum[8]};
    vr.pos_frac = frac_sum[7:0];
    if (next_pos >= vr.end_addr) begin
      next_pos = next_pos - vr.loop_span;
      if (vr.loop_span == '0) vr.speed = '0;
    end
    vr.pos_int = next_pos;
    return vr;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    voice_result_t want;
    voice_result_t got;
    voice_t        vr;
    logic [15:0]   sum;
    logic [15:0]   gain_prod;
    logic [15:0]   rel;
    int            n;
    int            vi;
    int            k;
    if (!rst_ni) begin
      for (k = 0; k < VOICES; k++) voices[k] = '0;
      active_voices = 4'd8;
      result_q.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      // result side first, so a word leaving on the same edge pops the older entry
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.mixed_sample, res_i.voice_position, res_i.voice_speed};
        if (result_q.size() == 0) begin
          $error({"unexpected result word: mixed_sample %0d voice_position 0x%06h",
                  " voice_speed 0x%04h"},
                 $signed(got.mixed), got.position, got.speed);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (got.mixed !== want.mixed) begin
            $error("mixed_sample: expected %0d, actual %0d",
                   $signed(want.mixed), $signed(got.mixed));
            mismatches++;
          end
          if (got.position !== want.position) begin
            $error("voice_position: expected 0x%06h, actual 0x%06h", want.position, got.position);
            mismatches++;
          end
          if (got.speed !== want.speed) begin
            $error("voice_speed: expected 0x%04h, actual 0x%04h", want.speed, got.speed);
            mismatches++;
          end
        end
      end

      if (cfg_i.valid && cfg_i.ready) active_voices = cfg_i.data;

      if (item_i.valid && item_i.ready) begin
        vi = int'(item_i.voice);
        case (action_e'(item_i.action))
          ACT_LOAD: begin
            sample_mem[int'(item_i.mem_address) % MEM_DEPTH] = item_i.sample_byte;
          end
          ACT_SETUP: begin
            if (vi < VOICES) begin
              vr.start_addr = item_i.start_address;
              vr.end_addr   = item_i.start_address + item_i.sample_length;
              vr.loop_span  = item_i.loop_length;
              vr.pos_int    = item_i.start_address + item_i.start_position[23:8];
              vr.pos_frac   = item_i.start_position[7:0];
              vr.speed      = item_i.step_speed;
              gain_prod     = item_i.voice_volume * item_i.envelope_level[15:EnvShift];
              vr.gain       = gain_prod[15:FracBits];
              voices[vi]    = vr;
            end
          end
          ACT_MIX: begin
            n   = (int'(active_voices) > VOICES) ? VOICES : int'(active_voices);
            sum = '0;
            for (k = 0; k < n; k++) begin
              if (voices[k].speed != '0) begin
                sum       = sum + voice_term(voices[k]);
                voices[k] = step_voice(voices[k]);
              end
            end
            result_q.push_back('{sum, 24'd0, 16'd0});
          end
          default: begin
            if (vi < VOICES) begin
              rel = voices[vi].pos_int - voices[vi].start_addr;
              result_q.push_back('{16'd0, {rel, voices[vi].pos_frac}, voices[vi].speed});
            end else begin
              result_q.push_back('0);
            end
          end
        endcase
      end
      pending_o <= result_q.size();
    end
  end

endmodule

@@ verif/tb_wavetable_voice_mixer_core.sv @@
// Testbench top for the wavetable voice mixer: stimulus, idling, watchdog and verdict.
module tb_wavetable_voice_mixer_core import wvm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VOICES      = 8;
  localparam int MEM_DEPTH   = 65536;
  localparam int WIN         = 64;   // bytes of the sample window used by moving voices
  localparam int PHASES      = 9;
  localparam int PHASE_WORDS = 65;
  localparam int SETTLE      = 40;   // longer than the slowest word (a mix)
  localparam int QUIET_LIMIT = 2000; // cycles with no handshake before giving up

  // One input word, all fields carried even where the action ignores them
  typedef struct packed {
    action_e     act;
    logic [15:0] mem_addr;
    logic [7:0]  sample_val;
    logic [2:0]  voice;
    logic [15:0] start_addr;
    logic [15:0] len;
    logic [15:0] loop_span;
    logic [23:0] position;
    logic [15:0] speed;
    logic [7:0]  volume;
    logic [15:0] envelope;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        calm;              // no idling on either side while set
  int          fail_count;
  int          pending;
  int          quiet = 0;
  int          n_words [4] = '{default: 0};
  int          n_cfg = 0;
  logic [15:0] win_base = 16'h4000;

  wvm_cfg_if cfg_bus ();
  wvm_in_if  item_bus ();
  wvm_out_if res_bus ();

  always #10 clk_i = ~clk_i;

  wavetable_voice_mixer_core #(
    .VOICES           (VOICES),
    .SAMPLE_MEM_DEPTH (MEM_DEPTH)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .item_i (item_bus),
    .res_o  (res_bus)
  );

  wvm_checker #(
    .VOICES    (VOICES),
    .MEM_DEPTH (MEM_DEPTH)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_bus),
    .item_i       (item_bus),
    .res_i        (res_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result side: short random stalls, none while calm
  initial begin
    int stall_left;
    stall_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (calm) begin
        res_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 3) begin
        res_bus.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake on any channel restarts the count
  always @(posedge clk_i) begin
    if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Every field random; callers then pin down what matters for the action
  function automatic word_t noise_word(input action_e a);
    word_t w;
    w.act        = a;
    w.mem_addr   = 16'($urandom);
    w.sample_val = 8'($urandom);
    w.voice      = 3'($urandom);
    w.start_addr = 16'($urandom);
    w.len        = 16'($urandom);
    w.loop_span  = 16'($urandom);
    w.position   = 24'($urandom);
    w.speed      = 16'($urandom);
    w.volume     = 8'($urandom);
    w.envelope   = 16'($urandom);
    return w;
  endfunction

  function automatic word_t load_word(input logic [15:0] addr, input logic [7:0] val);
    word_t w;
    w            = noise_word(ACT_LOAD);
    w.mem_addr   = addr;
    w.sample_val = val;
    return w;
  endfunction

  function automatic word_t read_word(input logic [2:0] v);
    word_t w;
    w       = noise_word(ACT_READ);
    w.voice = v;
    return w;
  endfunction

  function automatic word_t setup_word(input logic [2:0] v, input logic [15:0] start,
                                       input logic [15:0] len, input logic [15:0] loop_span,
                                       input logic [23:0] pos, input logic [15:0] speed,
                                       input logic [7:0] vol, input logic [15:0] env);
    word_t w;
    w            = noise_word(ACT_SETUP);
    w.voice      = v;
    w.start_addr = start;
    w.len        = len;
    w.loop_span  = loop_span;
    w.position   = pos;
    w.speed      = speed;
    w.volume     = vol;
    w.envelope   = env;
    return w;
  endfunction

  // A moving voice kept inside the loaded window: it starts before its end, and a
  // looping one steps back by no less than one step and no more than its length,
  // so every byte it fetches has been written. One-shot voices only move forward.
  function automatic word_t window_setup();
    word_t w;
    int    s_off;
    int    len;
    int    off;
    int    stepc;
    w            = noise_word(ACT_SETUP);
    s_off        = $urandom_range(0, WIN - 1);
    len          = $urandom_range(1, WIN - s_off);
    off          = $urandom_range(0, len - 1);
    w.start_addr = win_base + 16'(s_off);
    w.len        = 16'(len);
    w.position   = {16'(off), 8'($urandom)};
    if ($urandom_range(0, 1) == 0) begin
      w.loop_span = '0;
      w.speed     = 16'($urandom_range(1, 16'hFFFF));
    end else begin
      w.speed     = 16'($urandom_range(1, len * 256 - 1));
      stepc       = int'(w.speed[15:8]) + 1;
      w.loop_span = 16'($urandom_range(stepc, len));
    end
    return w;
  endfunction

  // Hand one word over; valid stays high unless a gap is drawn
  task automatic send_word(input word_t w);
    item_bus.valid          <= 1'b1;
    item_bus.action         <= w.act;
    item_bus.mem_address    <= w.mem_addr;
    item_bus.sample_byte    <= w.sample_val;
    item_bus.voice          <= w.voice;
    item_bus.start_address  <= w.start_addr;
    item_bus.sample_length  <= w.len;
    item_bus.loop_length    <= w.loop_span;
    item_bus.start_position <= w.position;
    item_bus.step_speed     <= w.speed;
    item_bus.voice_volume   <= w.volume;
    item_bus.envelope_level <= w.envelope;
    do @(posedge clk_i); while (item_bus.ready !== 1'b1);
    n_words[int'(w.act)]++;
    if (!calm && $urandom_range(0, 99) < 6) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Stop sending until every expected result has left; optionally let a trailing
  // load or set-up finish too
  task automatic drain(input bit settle);
    item_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    if (settle) repeat (SETTLE) @(posedge clk_i);
  endtask

  // The register is only written with the block idle
  task automatic set_active_voices(input logic [3:0] n);
    drain(1'b1);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= n;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    n_cfg++;
  endtask

  initial begin
    int pick;
    int ph;
    int j;
    int i;

    // every input known from time zero
    rst_ni                  <= 1'b0;
    calm                    <= 1'b0;
    cfg_bus.valid           <= 1'b0;
    cfg_bus.data            <= '0;
    item_bus.valid          <= 1'b0;
    item_bus.action         <= ACT_LOAD;
    item_bus.mem_address    <= '0;
    item_bus.sample_byte    <= '0;
    item_bus.voice          <= '0;
    item_bus.start_address  <= '0;
    item_bus.sample_length  <= '0;
    item_bus.loop_length    <= '0;
    item_bus.start_position <= '0;
    item_bus.step_speed     <= '0;
    item_bus.voice_volume   <= '0;
    item_bus.envelope_level <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // state straight out of reset: nothing moves, mix is zero
    send_word(read_word(3'd0));
    send_word(noise_word(ACT_MIX));

    // bytes at both ends of the address space, with sample extremes
    send_word(load_word(16'hFFFF, 8'h80));
    send_word(load_word(16'h0000, 8'h7F));
    send_word(load_word(16'h0001, 8'hFF));

    // one-shot voice whose end wraps past 0xFFFF: fetches 0xFFFF, then 0x0000 after
    // the position itself wraps, then stops; full volume and envelope
    send_word(setup_word(3'd7, 16'hFFFF, 16'd2, 16'd0, 24'h0, 16'h0100, 8'd255, 16'hFFFF));
    send_word(noise_word(ACT_MIX));
    send_word(noise_word(ACT_MIX));
    send_word(noise_word(ACT_MIX));   // stopped voice adds nothing
    send_word(read_word(3'd7));

    // looping voice on a negative byte: floor rounds away from zero
    send_word(setup_word(3'd0, 16'h0000, 16'd2, 16'd2, 24'h000180, 16'h0080, 8'd200,
                         16'h8000));
    send_word(noise_word(ACT_MIX));
    send_word(read_word(3'd0));

    // top speed, zero length and zero gain: one fetch, then stop
    send_word(setup_word(3'd1, 16'h0000, 16'd0, 16'd0, 24'h0, 16'hFFFF, 8'd255, 16'h0000));
    send_word(noise_word(ACT_MIX));
    send_word(read_word(3'd1));

    // all-ones record on a still voice; read-back position wraps
    send_word(setup_word(3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'h0000, 8'd255,
                         16'hFFFF));
    send_word(read_word(3'd2));

    // voice count: one, none, above the number of voices
    set_active_voices(4'd1);
    send_word(noise_word(ACT_MIX));
    send_word(noise_word(ACT_MIX));
    send_word(read_word(3'd0));
    set_active_voices(4'd0);
    send_word(noise_word(ACT_MIX));
    send_word(read_word(3'd0));
    set_active_voices(4'd15);
    send_word(noise_word(ACT_MIX));

    // ---- random part ----
    win_base = 16'($urandom_range(16'h0100, 16'hFD00));
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_active_voices(4'd8);
        1:       set_active_voices(4'd1);
        2:       set_active_voices(4'd15);
        default: set_active_voices(4'($urandom_range(0, 15)));
      endcase
      calm <= (ph == 3 || ph == 4);
      if (ph == 0) begin
        // fill the window before any voice is pointed at it
        for (i = 0; i < WIN; i++) send_word(load_word(win_base + 16'(i), 8'($urandom)));
      end
      for (j = 0; j < PHASE_WORDS; j++) begin
        if (ph == 5 && j == PHASE_WORDS / 2) drain(1'b0);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          send_word(load_word(win_base + 16'($urandom_range(0, WIN - 1)), 8'($urandom)));
        end else if (pick < 17) begin
          send_word(noise_word(ACT_LOAD));
        end else if (pick < 35) begin
          send_word(window_setup());
        end else if (pick < 40) begin
          // still voice: any record at all, never fetched
          send_word(setup_word(3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                               24'($urandom), 16'h0000, 8'($urandom), 16'($urandom)));
        end else if (pick < 80) begin
          send_word(noise_word(ACT_MIX));
        end else begin
          send_word(noise_word(ACT_READ));
        end
      end
    end
    calm <= 1'b0;

    // ---- wind down ----
    drain(1'b1);
    $display("Sent %0d loads, %0d voice set-ups, %0d mixes and %0d voice reads,",
             n_words[0], n_words[1], n_words[2], n_words[3]);
    $display("over %0d voice-count settings (0, 1, 8, 15 among them), window at 0x%04h.",
             n_cfg, win_base);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ wavetable_voice_mixer_core.f @@
src/wvm_pkg.sv
src/wvm_if.sv
src/wvm_ram.sv
src/wvm_mul.sv
src/wvm_voice_file.sv
src/wavetable_voice_mixer_core.sv
verif/wvm_checker.sv
verif/tb_wavetable_voice_mixer_core.sv
